// File: rtl/dq_pkg.sv
// Shared constants, types and word helpers for the double-ended queue.
package dq_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int WORD_W     = 32;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

    localparam logic signed [WORD_W-1:0] NONE_WORD = -32'sd1;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // Commands from the controller to the datapath, one step each.
    typedef struct packed {
        logic load;
        logic exec;
        logic rd_front;
        logic rd_back;
        logic capture_back;
    } dq_cmd_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_LAST) ? '0 : p + 1'b1;
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == '0) ? PTR_LAST : p - 1'b1;
        return r;
    endfunction

    // Word as it goes into storage: sign-extended or cut to the stored width.
    function automatic logic [DATA_WIDTH-1:0] to_store(input logic signed [WORD_W-1:0] v);
        logic signed [63:0] ext;
        ext = 64'(v);
        return ext[DATA_WIDTH-1:0];
    endfunction

    // Stored word back to a 32-bit result word.
    function automatic logic [WORD_W-1:0] from_store(input logic [DATA_WIDTH-1:0] w);
        logic signed [63:0] ext;
        ext = 64'(signed'(w));
        return ext[WORD_W-1:0];
    endfunction

endpackage

// File: rtl/dq_ctrl.sv
// Command sequencer for the double-ended queue.
module dq_ctrl
    import dq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    output logic    done,
    output dq_cmd_t cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_RD_FRONT = 3'd2;
    localparam logic [2:0] S_RD_BACK  = 3'd3;
    localparam logic [2:0] S_FIN      = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_RD_FRONT;
            end
            S_RD_FRONT:
            begin
                cmd.rd_front = 1'b1;
                state_next   = S_RD_BACK;
            end
            S_RD_BACK:
            begin
                cmd.rd_back = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                cmd.capture_back = 1'b1;
                done_next        = 1'b1;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe outside idle");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg == S_EXEC))
        else $error("accepted word did not start execution");

    a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> done_reg)
        else $error("finished command gave no result");

endmodule

// File: rtl/dq_datapath.sv
// Storage, pointers and result registers of the double-ended queue.
module dq_datapath
    import dq_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dq_cmd_t                     cmd,
    input  logic [MODE_W-1:0]           mode,
    input  logic signed [WORD_W-1:0]    value,
    output logic signed [WORD_W-1:0]    popped_value,
    output logic [STATUS_W-1:0]         status,
    output logic [CNT_W-1:0]            count,
    output logic                        is_empty,
    output logic signed [WORD_W-1:0]    front_value,
    output logic signed [WORD_W-1:0]    back_value
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [PTR_W-1:0]             head_reg, head_next;
    logic [PTR_W-1:0]             tail_reg, tail_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [MODE_W-1:0]            mode_reg;
    logic signed [WORD_W-1:0]     value_reg;
    logic [STATUS_W-1:0]          status_reg, status_next;
    logic                         pop_ok_reg, pop_ok_next;
    logic [DATA_WIDTH-1:0]        rdata_reg;
    logic [WORD_W-1:0]            popped_reg;
    logic [WORD_W-1:0]            front_reg;
    logic [WORD_W-1:0]            back_reg;

    logic                         mem_we;
    logic [PTR_W-1:0]             wr_addr;
    logic [PTR_W-1:0]             rd_addr;
    logic                         full;
    logic                         empty;
    logic [WORD_W-1:0]            rd_word;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign rd_word = from_store(rdata_reg);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pop_ok_next = pop_ok_reg;
        mem_we      = 1'b0;
        wr_addr     = tail_reg;
        rd_addr     = head_reg;
        if (cmd.exec)
        begin
            status_next = STATUS_DONE;
            pop_ok_next = 1'b0;
            unique case (mode_reg)
                MODE_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = STATUS_PUSH_FULL;
                    end
                    else
                    begin
                        head_next  = ptr_dec(head_reg);
                        wr_addr    = ptr_dec(head_reg);
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = STATUS_PUSH_FULL;
                    end
                    else
                    begin
                        wr_addr    = tail_reg;
                        tail_next  = ptr_inc(tail_reg);
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = STATUS_POP_EMPTY;
                    end
                    else
                    begin
                        rd_addr     = head_reg;
                        head_next   = ptr_inc(head_reg);
                        count_next  = count_reg - 1'b1;
                        pop_ok_next = 1'b1;
                    end
                end
                MODE_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = STATUS_POP_EMPTY;
                    end
                    else
                    begin
                        rd_addr     = ptr_dec(tail_reg);
                        tail_next   = ptr_dec(tail_reg);
                        count_next  = count_reg - 1'b1;
                        pop_ok_next = 1'b1;
                    end
                end
                default:
                begin
                    // query only
                end
            endcase
        end
        else if (cmd.rd_back)
        begin
            rd_addr = ptr_dec(tail_reg);
        end
    end

    // single write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= to_store(value_reg);
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode;
            value_reg <= value;
        end
        status_reg <= status_next;
        pop_ok_reg <= pop_ok_next;
        if (cmd.rd_front)
        begin
            popped_reg <= pop_ok_reg ? rd_word : NONE_WORD;
        end
        if (cmd.rd_back)
        begin
            front_reg <= rd_word;
        end
        if (cmd.capture_back)
        begin
            back_reg <= rd_word;
        end
    end

    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign count        = count_reg;
    assign is_empty     = empty;
    assign front_value  = empty ? NONE_WORD : front_reg;
    assign back_value   = empty ? NONE_WORD : back_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count above depth");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> $stable(count_reg))
        else $error("entry count moved outside execution");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && status_next == STATUS_PUSH_FULL) |=>
            ($stable(head_reg) && $stable(tail_reg)))
        else $error("dropped push moved a pointer");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= PTR_LAST) && (tail_reg <= PTR_LAST))
        else $error("pointer beyond depth");

endmodule

// File: rtl/double_ended_queue.sv
// Top level of the double-ended queue: controller and datapath.
//
// A command word is taken when start is high and busy is low. Each command
// (push front or back, pop front or back, query) gives one result, shown on
// the result ports for a single cycle with done high; the receiver cannot
// stall, so results must be captured in that cycle. A command runs through a
// sequence of controller states (accept, execute, front read, back read, finish)
// because the storage has a single registered read port and each command
// needs up to three reads; done is registered from the finish state and busy
// drops in that same cycle, so a new command can be accepted while done is
// high. Front and back values read -1 when the queue is empty; a push
// on a full queue is dropped and flagged. Storage is not cleared at reset.
module double_ended_queue
    import dq_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [MODE_W-1:0]           mode,
    input  logic signed [WORD_W-1:0]    value,
    output logic                        done,
    output logic signed [WORD_W-1:0]    popped_value,
    output logic [STATUS_W-1:0]         status,
    output logic [CNT_W-1:0]            count,
    output logic                        is_empty,
    output logic signed [WORD_W-1:0]    front_value,
    output logic signed [WORD_W-1:0]    back_value
);

    dq_cmd_t cmd;

    dq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    dq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .mode         (mode),
        .value        (value),
        .popped_value (popped_value),
        .status       (status),
        .count        (count),
        .is_empty     (is_empty),
        .front_value  (front_value),
        .back_value   (back_value)
    );

endmodule

// File: dv/tb_double_ended_queue.sv
// Self-checking testbench for the double-ended queue: directed table, then random near-empty, fill and full phases.
module tb_double_ended_queue;
    import dq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_UNUSED_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    localparam int IDLE_LIMIT = 1000;

    typedef struct {
        logic signed [WORD_W-1:0] popped;
        logic [STATUS_W-1:0]      status;
        logic [CNT_W-1:0]         count;
        logic                     is_empty;
        logic signed [WORD_W-1:0] front;
        logic signed [WORD_W-1:0] back;
    } deque_result_t;

    typedef struct {
        logic [MODE_W-1:0]        mode;
        logic signed [WORD_W-1:0] value;
        logic                     typed;
        deque_result_t            result;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [MODE_W-1:0]        mode = '0;
    logic signed [WORD_W-1:0] value = '0;
    logic                     busy;
    logic                     done;
    logic signed [WORD_W-1:0] popped_value;
    logic [STATUS_W-1:0]      status;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;

    // shadow copy of the deque, updated as each command word is accepted
    logic [DATA_WIDTH-1:0] mirror_mem [DEPTH];
    logic [PTR_W-1:0]      mirror_head = '0;
    logic [PTR_W-1:0]      mirror_tail = '0;
    logic [CNT_W-1:0]      mirror_count = '0;

    deque_result_t deque_results [$];
    stim_row_t     directed_rows [$];
    deque_result_t no_result;
    int            burst_left = 0;
    int            idle_cycles = 0;
    bit            failed = 1'b0;

    double_ended_queue u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .value        (value),
        .done         (done),
        .popped_value (popped_value),
        .status       (status),
        .count        (count),
        .is_empty     (is_empty),
        .front_value  (front_value),
        .back_value   (back_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] prev_slot(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
    endfunction

    // stored word sign-extended back to the result width
    function automatic logic signed [WORD_W-1:0] read_slot(input logic [PTR_W-1:0] p);
        logic signed [DATA_WIDTH-1:0] w;
        w = mirror_mem[p];
        return WORD_W'(w);
    endfunction

    task automatic deque_apply(input logic [MODE_W-1:0] m, input logic signed [WORD_W-1:0] v,
                               output deque_result_t r);
        logic [DATA_WIDTH-1:0] word;
        word = DATA_WIDTH'(v);
        r.popped = NONE_WORD;
        r.status = STATUS_DONE;
        case (m)
            MODE_PUSH_FRONT, MODE_PUSH_BACK:
            begin
                if (mirror_count == CNT_W'(DEPTH))
                    r.status = STATUS_PUSH_FULL;
                else if (m == MODE_PUSH_FRONT)
                begin
                    mirror_head = prev_slot(mirror_head);
                    mirror_mem[mirror_head] = word;
                    mirror_count = mirror_count + 1'b1;
                end
                else
                begin
                    mirror_mem[mirror_tail] = word;
                    mirror_tail = next_slot(mirror_tail);
                    mirror_count = mirror_count + 1'b1;
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK:
            begin
                if (mirror_count == '0)
                    r.status = STATUS_POP_EMPTY;
                else if (m == MODE_POP_FRONT)
                begin
                    r.popped = read_slot(mirror_head);
                    mirror_head = next_slot(mirror_head);
                    mirror_count = mirror_count - 1'b1;
                end
                else
                begin
                    mirror_tail = prev_slot(mirror_tail);
                    r.popped = read_slot(mirror_tail);
                    mirror_count = mirror_count - 1'b1;
                end
            end
            default: ;
        endcase
        r.count = mirror_count;
        r.is_empty = (mirror_count == '0);
        r.front = r.is_empty ? NONE_WORD : read_slot(mirror_head);
        r.back = r.is_empty ? NONE_WORD : read_slot(prev_slot(mirror_tail));
    endtask

    task automatic row_typed(input logic [MODE_W-1:0] m, input logic signed [WORD_W-1:0] v,
                             input logic signed [WORD_W-1:0] popped, input logic [STATUS_W-1:0] st,
                             input int cnt, input logic signed [WORD_W-1:0] front,
                             input logic signed [WORD_W-1:0] back);
        stim_row_t row;
        row.mode = m;
        row.value = v;
        row.typed = 1'b1;
        row.result.popped = popped;
        row.result.status = st;
        row.result.count = CNT_W'(cnt);
        row.result.is_empty = (cnt == 0);
        row.result.front = front;
        row.result.back = back;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic row_pred(input logic [MODE_W-1:0] m, input logic signed [WORD_W-1:0] v);
        stim_row_t row;
        row.mode = m;
        row.value = v;
        row.typed = 1'b0;
        row.result = no_result;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Called in the time step of a rising edge; returns in the step of the accepting edge
    // with start still high, so a back-to-back word keeps it up.
    task automatic send_cmd(input logic [MODE_W-1:0] m, input logic signed [WORD_W-1:0] v,
                            input logic typed, input deque_result_t typed_result);
        int gap;
        deque_result_t pred;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 29) == 0)
                burst_left = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode <= m;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        deque_apply(m, v, pred);
        deque_results.insert(deque_results.size(), typed ? typed_result : pred);
    endtask

    task automatic send_random(input int push_pct, input int pop_pct);
        int r;
        logic [MODE_W-1:0] m;
        logic signed [WORD_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            m = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        else if (r < push_pct + pop_pct)
            m = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
        else if ($urandom_range(0, 1))
            m = MODE_QUERY;
        else
            m = MODE_W'($urandom_range(MODE_UNUSED_5, MODE_UNUSED_7));
        case ($urandom_range(0, 7))
            0: v = WORD_MAX;
            1: v = WORD_MIN;
            2: v = NONE_WORD;
            3: v = '0;
            default: v = $urandom();
        endcase
        send_cmd(m, v, 1'b0, no_result);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (deque_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_result();
        deque_result_t want;
        want = deque_results[0];
        deque_results.delete(0);
        if (popped_value !== want.popped)
        begin
            $error("popped_value: expected %0d, actual %0d", want.popped, popped_value);
            failed = 1'b1;
        end
        if (status !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, status);
            failed = 1'b1;
        end
        if (count !== want.count)
        begin
            $error("count: expected %0d, actual %0d", want.count, count);
            failed = 1'b1;
        end
        if (is_empty !== want.is_empty)
        begin
            $error("is_empty: expected %0d, actual %0d", want.is_empty, is_empty);
            failed = 1'b1;
        end
        if (front_value !== want.front)
        begin
            $error("front_value: expected %0d, actual %0d", want.front, front_value);
            failed = 1'b1;
        end
        if (back_value !== want.back)
        begin
            $error("back_value: expected %0d, actual %0d", want.back, back_value);
            failed = 1'b1;
        end
    endtask

    // result words are sampled at the edge that ends their strobe cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (deque_results.size() == 0)
            begin
                $error("result word with no expectation waiting");
                failed = 1'b1;
            end
            else
                check_result();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        no_result = '{NONE_WORD, STATUS_DONE, '0, 1'b1, NONE_WORD, NONE_WORD};

        // from reset: empty reads, both extremes through both ends
        row_typed(MODE_QUERY, '0, NONE_WORD, STATUS_DONE, 0, NONE_WORD, NONE_WORD);
        row_typed(MODE_POP_FRONT, WORD_MAX, NONE_WORD, STATUS_POP_EMPTY, 0, NONE_WORD, NONE_WORD);
        row_typed(MODE_POP_BACK, WORD_MIN, NONE_WORD, STATUS_POP_EMPTY, 0, NONE_WORD, NONE_WORD);
        row_typed(MODE_PUSH_FRONT, WORD_MAX, NONE_WORD, STATUS_DONE, 1, WORD_MAX, WORD_MAX);
        row_typed(MODE_PUSH_BACK, WORD_MIN, NONE_WORD, STATUS_DONE, 2, WORD_MAX, WORD_MIN);
        row_typed(MODE_POP_BACK, '0, WORD_MIN, STATUS_DONE, 1, WORD_MAX, WORD_MAX);
        row_typed(MODE_POP_FRONT, '0, WORD_MAX, STATUS_DONE, 0, NONE_WORD, NONE_WORD);
        row_pred(MODE_PUSH_BACK, '0);
        row_pred(MODE_PUSH_BACK, NONE_WORD);
        row_pred(MODE_PUSH_FRONT, 32'sh5555_5555);
        row_pred(MODE_PUSH_FRONT, 32'shAAAA_AAAA);
        row_pred(MODE_UNUSED_5, 32'sh1234_5678);
        row_pred(MODE_UNUSED_6, WORD_MIN);
        row_pred(MODE_UNUSED_7, WORD_MAX);
        row_pred(MODE_POP_FRONT, '0);
        row_pred(MODE_POP_BACK, '0);
        row_pred(MODE_POP_BACK, '0);
        row_pred(MODE_POP_FRONT, '0);
        row_typed(MODE_POP_FRONT, '0, NONE_WORD, STATUS_POP_EMPTY, 0, NONE_WORD, NONE_WORD);
        row_pred(MODE_PUSH_FRONT, 32'sd1);
        row_pred(MODE_POP_BACK, '0);
        row_pred(MODE_PUSH_BACK, 32'sh8000_0001);
        row_pred(MODE_PUSH_FRONT, 32'sh7FFF_FFFE);
        row_pred(MODE_QUERY, NONE_WORD);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].mode, directed_rows[i].value,
                     directed_rows[i].typed, directed_rows[i].result);

        // near empty: many pops on an empty deque
        repeat (40)
            send_random(35, 40);

        drain_results();

        // fill until full with pushes at both ends
        while (mirror_count != CNT_W'(DEPTH))
            send_random(94, 3);

        // hover at full so pushes get dropped
        repeat (40)
            send_random(50, 30);

        drain_results();
        repeat (8) @(posedge clk);

        if (!failed)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
